FILE: src/sit_pkg.sv
// ---------------------------------------------------------------------------
// sit_pkg
// Shared types and codes for the string intern table: result status codes,
// sequencer states, field widths and the pending string buffer control bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

	// fixed widths of the result fields and the character
	localparam int OFFSET_W = 12;
	localparam int STATUS_W = 2;
	localparam int CHAR_W   = 8;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND = 2'd0,
		ST_ADDED = 2'd1,
		ST_FULL  = 2'd2,
		ST_LONG  = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_COLLECT,
		S_SCAN,
		S_COPY,
		S_RESULT
	} state_t;

	// control toward the pending string buffer
	typedef struct packed {
		logic push;
		logic clear;
	} pend_ctl_t;

endpackage

`default_nettype wire

FILE: src/string_intern_table_unit.sv
// ---------------------------------------------------------------------------
// string_intern_table_unit
// String interning table: takes a string one byte per beat, and on the zero
// terminator gives an identical stored string's offset, appends it, or fails.
// ---------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall with char_byte. Each nonzero byte is
//   taken and stored in the pending buffer while it has room. A zero byte
//   ends the string; in_stall then stays high until the result is placed
//   in the output register.
//   Output channel: out_valid / out_stall with string_offset and status; one
//   result beat per terminator and none for other bytes.
//   Handling of a terminator: the scan reads the table memory one byte per
//   cycle from offset 1 up to the first match; an append then copies the
//   string at one byte per cycle and writes its terminator; then the output
//   register is loaded. An over-long string skips scan and copy and only
//   loads the output register. The table memory read port sets the rate:
//   one stored byte per cycle.
//   Reset empties the table (fill level 1) and the pending buffer; no
//   memory clearing pass is needed, only written bytes are ever read.
//   While the receiver stalls, the result waits in the output register and
//   new bytes are still taken; the next terminator waits until the output
//   register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module string_intern_table_unit #(
	parameter int TABLE_BYTES      = 4096,
	parameter int MAX_STRING_BYTES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sit_pkg::CHAR_W-1:0]     char_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sit_pkg::OFFSET_W-1:0]   string_offset,
	output logic [sit_pkg::STATUS_W-1:0]   status
);
	import sit_pkg::*;

	localparam int TW = $clog2(TABLE_BYTES);
	localparam int LW = $clog2(MAX_STRING_BYTES);
	localparam int IW = ((TW > LW) ? TW : LW) + 1;
	localparam int SW = IW + 1;

	state_t            state_q, state_d;
	logic [TW:0]       fill_q;
	logic [TW:0]       p_q;

	logic [CHAR_W-1:0] tbl_mem [0:TABLE_BYTES-1];
	logic [CHAR_W-1:0] tbl_rd_s1;
	logic              tbl_we;
	logic [TW-1:0]     tbl_waddr;
	logic [CHAR_W-1:0] tbl_wdata;

	logic              valid_s1;
	logic [TW-1:0]     addr_s1;
	logic [IW-1:0]     idx_s1;
	logic              same_q;
	logic [TW-1:0]     start_q;

	logic [LW-1:0]     k_q;
	logic              cp_valid_s1;
	logic [TW-1:0]     cp_addr_s1;

	logic [TW-1:0]     res_off_q;
	status_t           res_st_q;
	logic              out_valid_q;
	logic [TW-1:0]     out_off_q;
	status_t           out_st_q;

	pend_ctl_t         pend_ctl;
	logic [LW-1:0]     pend_idx;
	logic [LW-1:0]     pend_len;
	logic [CHAR_W-1:0] pend_rd;
	logic              pend_ovf;

	logic              in_acc;
	logic              term;
	logic [IW-1:0]     len_ext;
	logic [IW-1:0]     idx_issue;
	logic              s1_end;
	logic              s1_hit;
	logic              s1_miss;
	logic              scan_more;
	logic              issue;
	logic              scan_none;
	logic [SW-1:0]     need;
	logic              no_room;
	logic              cp_issue;
	logic              cp_done;
	logic              load;

	// pending string buffer
	sit_pend #(
		.MAX_STRING_BYTES(MAX_STRING_BYTES)
	) u_pend (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pend_ctl),
		.char_byte (char_byte),
		.rd_idx    (pend_idx),
		.rd_data   (pend_rd),
		.len       (pend_len),
		.overflow  (pend_ovf)
	);

	// input beat and terminator
	assign in_acc = in_valid && (state_q == S_COLLECT);
	assign term   = in_acc && (char_byte == '0);

	// scan compare on the byte read last cycle
	assign len_ext   = IW'(pend_len);
	assign s1_end    = valid_s1 && (tbl_rd_s1 == '0);
	assign s1_hit    = s1_end && same_q && (idx_s1 == len_ext);
	assign s1_miss   = valid_s1 && !s1_end &&
		((idx_s1 >= len_ext) || (tbl_rd_s1 != pend_rd));
	assign scan_more = (p_q < fill_q);
	assign issue     = (state_q == S_SCAN) && !s1_hit && scan_more;
	assign scan_none = (state_q == S_SCAN) && !valid_s1 && !scan_more;

	// pending index restarts at zero right after a stored terminator
	assign idx_issue = s1_end ? '0 : (valid_s1 ? (idx_s1 + IW'(1)) : '0);

	// room check for an append: string plus its terminator
	assign need    = SW'(fill_q) + SW'(pend_len) + SW'(1);
	assign no_room = (need > SW'(TABLE_BYTES));

	// copy sequencing
	assign cp_issue = (state_q == S_COPY) && (k_q != pend_len);
	assign cp_done  = (state_q == S_COPY) && (k_q == pend_len) && !cp_valid_s1;

	// result hand-off into the output register
	assign load = (state_q == S_RESULT) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_COLLECT: begin
				if (term) begin
					state_d = pend_ovf ? S_RESULT : S_SCAN;
				end
			end
			S_SCAN: begin
				if (s1_hit) begin
					state_d = S_RESULT;
				end else if (scan_none) begin
					state_d = no_room ? S_RESULT : S_COPY;
				end
			end
			S_COPY: begin
				if (cp_done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (load) begin
					state_d = S_COLLECT;
				end
			end
			default: state_d = S_COLLECT;
		endcase
	end

	// control outputs per state
	always_comb begin
		pend_ctl.push  = 1'b0;
		pend_ctl.clear = 1'b0;
		pend_idx       = idx_issue[LW-1:0];
		tbl_we         = 1'b0;
		tbl_waddr      = cp_addr_s1;
		tbl_wdata      = pend_rd;
		case (state_q)
			S_COLLECT: begin
				pend_ctl.push = in_acc && (char_byte != '0);
			end
			S_SCAN: begin
				pend_idx = idx_issue[LW-1:0];
			end
			S_COPY: begin
				pend_idx = k_q;
				if (cp_valid_s1) begin
					tbl_we = 1'b1;
				end else if (cp_done) begin
					tbl_we    = 1'b1;
					tbl_waddr = fill_q[TW-1:0] + TW'(pend_len);
					tbl_wdata = '0;
				end
			end
			S_RESULT: begin
				pend_ctl.clear = load;
			end
			default: begin
				pend_ctl.clear = 1'b0;
			end
		endcase
	end

	// state, fill level and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			fill_q      <= (TW+1)'(1);
			valid_s1    <= 1'b0;
			cp_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			valid_s1    <= issue;
			cp_valid_s1 <= cp_issue;
			if (cp_done) begin
				fill_q <= fill_q + (TW+1)'(pend_len) + (TW+1)'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan, copy and result payload
	always_ff @(posedge clk) begin
		if (term) begin
			p_q       <= (TW+1)'(1);
			same_q    <= 1'b1;
			start_q   <= TW'(1);
			res_off_q <= '0;
			res_st_q  <= ST_LONG;
		end
		if (issue) begin
			p_q <= p_q + (TW+1)'(1);
		end
		addr_s1 <= p_q[TW-1:0];
		idx_s1  <= idx_issue;
		if (s1_end) begin
			same_q  <= 1'b1;
			start_q <= addr_s1 + TW'(1);
		end else if (s1_miss) begin
			same_q <= 1'b0;
		end
		if (s1_hit) begin
			res_off_q <= start_q;
			res_st_q  <= ST_FOUND;
		end else if (scan_none) begin
			k_q <= '0;
			if (no_room) begin
				res_off_q <= '0;
				res_st_q  <= ST_FULL;
			end else begin
				res_off_q <= fill_q[TW-1:0];
				res_st_q  <= ST_ADDED;
			end
		end
		if (cp_issue) begin
			k_q <= k_q + LW'(1);
		end
		cp_addr_s1 <= fill_q[TW-1:0] + TW'(k_q);
		if (load) begin
			out_off_q <= res_off_q;
			out_st_q  <= res_st_q;
		end
	end

	// string table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		tbl_rd_s1 <= tbl_mem[p_q[TW-1:0]];
	end

	assign in_stall      = (state_q != S_COLLECT);
	assign out_valid     = out_valid_q;
	assign string_offset = OFFSET_W'(out_off_q);
	assign status        = out_st_q;

	// no table write while a scan read is in flight
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> !valid_s1)
		else $error("table write during scan read");

	// a match goes straight to the result with found status
	a_hit_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_hit |=> (state_q == S_RESULT) && (res_st_q == ST_FOUND))
		else $error("match did not produce found result");

	// failures always report offset zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load && ((res_st_q == ST_FULL) || (res_st_q == ST_LONG))
		|=> (string_offset == '0))
		else $error("failure result with nonzero offset");

	// fill level stays within the table
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0) && (fill_q <= (TW+1)'(TABLE_BYTES)))
		else $error("fill level out of range");

endmodule

`default_nettype wire

FILE: src/sit_pend.sv
// ---------------------------------------------------------------------------
// sit_pend
// Pending string buffer: collects the bytes of the string being entered in
// a synchronous memory, tracks its length and an overflow flag, and serves
// one registered read per cycle to the lookup and append sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module sit_pend #(
	parameter int MAX_STRING_BYTES = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sit_pkg::pend_ctl_t                   ctl,
	input  logic [sit_pkg::CHAR_W-1:0]           char_byte,
	input  logic [$clog2(MAX_STRING_BYTES)-1:0]  rd_idx,
	output logic [sit_pkg::CHAR_W-1:0]           rd_data,
	output logic [$clog2(MAX_STRING_BYTES)-1:0]  len,
	output logic                                 overflow
);
	import sit_pkg::*;

	localparam int LW = $clog2(MAX_STRING_BYTES);

	logic [CHAR_W-1:0] pend_mem [0:MAX_STRING_BYTES-1];
	logic [LW-1:0]     len_q;
	logic              ovf_q;
	logic              has_room;
	logic              wr_en;

	// room for one more byte before the terminator
	assign has_room = (len_q != LW'(MAX_STRING_BYTES - 1));
	assign wr_en    = ctl.push && has_room;

	// length and overflow tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.clear) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.push) begin
			if (has_room) begin
				len_q <= len_q + LW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// byte storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pend_mem[len_q] <= char_byte;
		end
		rd_data <= pend_mem[rd_idx];
	end

	assign len      = len_q;
	assign overflow = ovf_q;

	// length stays within the buffer
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_STRING_BYTES - 1))
		else $error("pending length beyond buffer");

	// a byte that does not fit raises the overflow flag
	a_ovf_set: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push && !ctl.clear && !has_room |=> ovf_q && $stable(len_q))
		else $error("dropped byte did not set overflow");

	// clearing empties the buffer
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> (len_q == '0) && !ovf_q)
		else $error("pending buffer not cleared");

endmodule

`default_nettype wire
